FILE: sv/bmp24_pkg.sv
// Shared types and constants of the 24-bit BMP stream parser.
package bmp24_pkg;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_CORRUPT = 2'd2;

   localparam int HDR_BYTES = 54;
   localparam int CAP_BYTES = 30;
   localparam int MIN_FILE  = 58;
   localparam int POS_W     = 6;
   localparam int COORD_W   = 12;

   localparam logic [7:0]  SIG_B        = 8'h42;
   localparam logic [7:0]  SIG_M        = 8'h4d;
   localparam logic [31:0] DATA_OFFSET  = 32'h0000_0036;
   localparam logic [31:0] INFO_SIZE    = 32'h0000_0028;
   localparam logic [31:0] PLANES_DEPTH = 32'h0018_0001;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        start_of_file;
      logic [31:0] file_bytes;
   } req_payload_type;

   typedef struct packed {
      logic               is_pixel;
      logic [7:0]         pixel_blue;
      logic [7:0]         pixel_green;
      logic [7:0]         pixel_red;
      logic [COORD_W-1:0] pixel_row;
      logic [COORD_W-1:0] pixel_col;
      logic [1:0]         status;
      logic               last;
   } rsp_payload_type;

   // header capture controls from the sequencer
   typedef struct packed {
      logic             load_len;
      logic [31:0]      len;
      logic             wr;
      logic [POS_W-1:0] pos;
      logic [7:0]       data;
   } hdr_wr_type;

endpackage

FILE: sv/bmp24_if.sv
// Valid/ready channel interfaces for the request and response streams.
interface bmp24_req_if;
   import bmp24_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bmp24_rsp_if;
   import bmp24_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/bmp24_hdr.sv
// Header byte capture, image size product and header check.
module bmp24_hdr #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                  clock,
   input  bmp24_pkg::hdr_wr_type hdr_wr,
   output logic [1:0]            check_status,
   output logic [WW-1:0]         image_width,
   output logic [HW-1:0]         image_height,
   output logic [1:0]            row_pad
);
   import bmp24_pkg::*;

   localparam int LW = WW + 2;
   localparam int PW = HW + LW;
   localparam int CW = (PW + 1 > 32) ? PW + 1 : 32;

   logic [7:0]    hdr_ff [CAP_BYTES];
   logic [31:0]   length_ff;
   logic [PW-1:0] product_ff;
   logic [PW-1:0] product_in;

   logic [31:0]   file_size, reserved, offset, info, width32, height32, planes;
   logic [LW-1:0] line_bytes;
   logic [CW-1:0] calc;
   logic          bad_format;

   always_ff @(posedge clock) begin
      if (hdr_wr.load_len) length_ff <= hdr_wr.len;
      if (hdr_wr.wr && hdr_wr.pos < POS_W'(CAP_BYTES)) hdr_ff[hdr_wr.pos[4:0]] <= hdr_wr.data;
      product_ff <= product_in;
   end

   assign file_size = {hdr_ff[5],  hdr_ff[4],  hdr_ff[3],  hdr_ff[2]};
   assign reserved  = {hdr_ff[9],  hdr_ff[8],  hdr_ff[7],  hdr_ff[6]};
   assign offset    = {hdr_ff[13], hdr_ff[12], hdr_ff[11], hdr_ff[10]};
   assign info      = {hdr_ff[17], hdr_ff[16], hdr_ff[15], hdr_ff[14]};
   assign width32   = {hdr_ff[21], hdr_ff[20], hdr_ff[19], hdr_ff[18]};
   assign height32  = {hdr_ff[25], hdr_ff[24], hdr_ff[23], hdr_ff[22]};
   assign planes    = {hdr_ff[29], hdr_ff[28], hdr_ff[27], hdr_ff[26]};

   assign image_width  = width32[WW-1:0];
   assign image_height = height32[HW-1:0];
   // (4 - 3w mod 4) mod 4 reduces to w mod 4
   assign row_pad      = width32[1:0];

   // Width and height settle long before the last header byte, so the product
   // is registered and only the add and compare sit in the check path.
   assign line_bytes = ({2'b00, image_width} << 1) + {2'b00, image_width} + LW'(row_pad);
   assign product_in = PW'(image_height) * PW'(line_bytes);
   assign calc       = CW'(product_ff) + CW'(HDR_BYTES);

   always_comb begin
      bad_format = (hdr_ff[0] != SIG_B) || (hdr_ff[1] != SIG_M)
                || (file_size != length_ff) || (reserved != '0)
                || (offset != DATA_OFFSET) || (info != INFO_SIZE)
                || (planes != PLANES_DEPTH)
                || (width32 == '0) || (width32 > 32'(MAX_WIDTH))
                || (height32 == '0) || (height32 > 32'(MAX_HEIGHT));
      if (bad_format) begin
         check_status = ST_INVALID;
      end else if (calc != CW'(length_ff)) begin
         check_status = ST_CORRUPT;
      end else begin
         check_status = ST_OK;
      end
   end

endmodule

FILE: sv/bmp24_ctl.sv
// Parse sequencer: file phases, pixel assembly, row and column counters, padding check.
module bmp24_ctl #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  bmp24_pkg::req_payload_type req,
   input  logic [1:0]                 check_status,
   input  logic [WW-1:0]              image_width,
   input  logic [HW-1:0]              image_height,
   input  logic [1:0]                 row_pad,
   output bmp24_pkg::hdr_wr_type      hdr_wr,
   output logic                       res_valid,
   output bmp24_pkg::rsp_payload_type res
);
   import bmp24_pkg::*;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_PIXELS = 3'd2;
   localparam logic [2:0] PH_PAD    = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   logic [2:0]       phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       triple_ff, triple_in;
   logic [15:0]      partial_ff, partial_in;
   logic [HW-1:0]    row_ff, row_in;
   logic [WW-1:0]    col_ff, col_in;
   logic [1:0]       padc_ff, padc_in;
   logic             padbad_ff, padbad_in;

   logic [2:0]       phase_cur;
   logic [POS_W-1:0] pos_cur;
   logic [HW-1:0]    row_next, row_img;
   logic [WW-1:0]    col_next;
   logic [2:0]       pc_next;
   logic             bad;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      triple_in  = triple_ff;
      partial_in = partial_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      padc_in    = padc_ff;
      padbad_in  = padbad_ff;
      res_valid  = 1'b0;
      res        = '0;

      hdr_wr.load_len = accept && req.start_of_file;
      hdr_wr.len      = req.file_bytes;
      hdr_wr.data     = req.data_byte;
      hdr_wr.wr       = 1'b0;
      hdr_wr.pos      = pos_ff;

      row_next = row_ff + HW'(1);
      col_next = col_ff + WW'(1);
      row_img  = image_height - HW'(1) - row_ff;
      pc_next  = {1'b0, padc_ff} + 3'd1;
      bad      = padbad_ff || (req.data_byte != 8'd0);

      phase_cur = phase_ff;
      pos_cur   = pos_ff;

      if (accept) begin
         if (req.start_of_file) begin
            phase_cur = PH_HEADER;
            pos_cur   = '0;
            if (req.file_bytes < 32'(MIN_FILE)) begin
               phase_cur  = PH_DONE;
               phase_in   = PH_DONE;
               res_valid  = 1'b1;
               res.status = ST_INVALID;
               res.last   = 1'b1;
            end
         end

         case (phase_cur)
            PH_HEADER: begin
               hdr_wr.wr  = 1'b1;
               hdr_wr.pos = pos_cur;
               pos_in     = pos_cur + POS_W'(1);
               phase_in   = PH_HEADER;
               if (pos_cur == POS_W'(HDR_BYTES - 1)) begin
                  if (check_status != ST_OK) begin
                     res_valid  = 1'b1;
                     res.status = check_status;
                     res.last   = 1'b1;
                     phase_in   = PH_DONE;
                  end else begin
                     phase_in  = PH_PIXELS;
                     triple_in = '0;
                     row_in    = '0;
                     col_in    = '0;
                  end
               end
            end

            PH_PIXELS: begin
               if (triple_ff == 2'd0) begin
                  partial_in[7:0] = req.data_byte;
                  triple_in       = 2'd1;
               end else if (triple_ff == 2'd1) begin
                  partial_in[15:8] = req.data_byte;
                  triple_in        = 2'd2;
               end else begin
                  res_valid       = 1'b1;
                  res.is_pixel    = 1'b1;
                  res.pixel_blue  = partial_ff[7:0];
                  res.pixel_green = partial_ff[15:8];
                  res.pixel_red   = req.data_byte;
                  res.pixel_row   = COORD_W'(row_img);
                  res.pixel_col   = COORD_W'(col_ff);
                  res.status      = ST_OK;
                  triple_in       = '0;
                  col_in          = col_next;
                  if (col_next >= image_width) begin
                     col_in = '0;
                     if (row_pad == 2'd0) begin
                        row_in = row_next;
                        if (row_next >= image_height) begin
                           res.last = 1'b1;
                           phase_in = PH_DONE;
                        end
                     end else begin
                        phase_in  = PH_PAD;
                        padc_in   = '0;
                        padbad_in = 1'b0;
                     end
                  end
               end
            end

            PH_PAD: begin
               padbad_in = bad;
               padc_in   = pc_next[1:0];
               if (pc_next >= {1'b0, row_pad}) begin
                  padc_in = '0;
                  row_in  = row_next;
                  if (bad) begin
                     res_valid  = 1'b1;
                     res.status = ST_CORRUPT;
                     res.last   = 1'b1;
                     phase_in   = PH_DONE;
                  end else if (row_next >= image_height) begin
                     res_valid  = 1'b1;
                     res.status = ST_OK;
                     res.last   = 1'b1;
                     phase_in   = PH_DONE;
                  end else begin
                     phase_in = PH_PIXELS;
                  end
               end
            end

            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         triple_ff <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         padc_ff   <= '0;
         padbad_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         triple_ff <= triple_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         padc_ff   <= padc_in;
         padbad_ff <= padbad_in;
      end
   end

   always_ff @(posedge clock) begin
      partial_ff <= partial_in;
   end

endmodule

FILE: sv/bmp24_stream_parser.sv
// Top level of the 24-bit BMP stream parser: channels, result register and checks.
// The parser takes one file byte per cycle and can accept a byte on every cycle; each
// byte's result, if any, appears in the response register in the cycle after the transfer,
// and a byte is still taken while a finished result waits, as long as the response side
// drains it in the same cycle. The rate is set by the single response register: a
// stalled response holds back the request side. A byte with start_of_file set restarts
// parsing and samples file_bytes; a file under 58 bytes gets an invalid result. After
// the 54th header byte the header is checked and a bad file gets one status result
// (1 invalid, 2 corrupted) with last set; a good one goes on to emit one pixel result
// per B,G,R triple, rows from height-1 down to 0, columns upward, with row padding
// checked for zero. Image size is bounded by the MAX_WIDTH and MAX_HEIGHT parameters.
module bmp24_stream_parser #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input logic         clock,
   input logic         reset,
   bmp24_req_if.sink   req_chan,
   bmp24_rsp_if.source rsp_chan
);
   import bmp24_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic            accept;
   logic            res_valid;
   rsp_payload_type res;
   hdr_wr_type      hdr_wr;
   logic [1:0]      check_status;
   logic [WW-1:0]   image_width;
   logic [HW-1:0]   image_height;
   logic [1:0]      row_pad;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   bmp24_hdr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_hdr (
      .clock        (clock),
      .hdr_wr       (hdr_wr),
      .check_status (check_status),
      .image_width  (image_width),
      .image_height (image_height),
      .row_pad      (row_pad)
   );

   bmp24_ctl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req_chan.payload),
      .check_status (check_status),
      .image_width  (image_width),
      .image_height (image_height),
      .row_pad      (row_pad),
      .hdr_wr       (hdr_wr),
      .res_valid    (res_valid),
      .res          (res)
   );

   // a new transfer in may replace a result leaving in the same cycle
   assign rsp_valid_in = accept ? res_valid : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) rsp_payload_ff <= res;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   a_pixel_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.is_pixel |-> rsp_chan.payload.status == ST_OK)
      else $error("pixel result with non-ok status");

   a_status_last : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.is_pixel |-> rsp_chan.payload.last)
      else $error("status-only result not marked last");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.status == ST_OK ||
                          rsp_chan.payload.status == ST_INVALID ||
                          rsp_chan.payload.status == ST_CORRUPT))
      else $error("undefined status code");

   a_status_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.is_pixel |->
         rsp_chan.payload.pixel_row == '0 && rsp_chan.payload.pixel_col == '0)
      else $error("status-only result carries coordinates");

endmodule
